[src/fcq_pkg.sv]
`default_nettype none
package fcq_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 17;
    localparam int FILT_W   = 32;
    localparam int TAP_W    = 6;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int Q15_SHIFT = 15;

    typedef logic [1:0]                 action_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [FILT_W-1:0]   filt_t;
    typedef logic [TAP_W-1:0]           tap_t;

    localparam action_t ACT_FILTER = 2'd0;
    localparam action_t ACT_COEF   = 2'd1;
    localparam action_t ACT_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WRITE,
        ST_RUN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic data_valid;
    } mac_ctrl_t;

endpackage
`default_nettype wire

[src/fcq_in_if.sv]
`default_nettype none
interface fcq_in_if;
    logic               valid;
    logic               ready;
    fcq_pkg::action_t   action;
    fcq_pkg::sample_t   sample;
    fcq_pkg::tap_t      tap_index;
    fcq_pkg::coef_t     coefficient;

    modport source (output valid, output action, output sample, output tap_index,
                    output coefficient, input ready);
    modport sink (input valid, input action, input sample, input tap_index,
                  input coefficient, output ready);
endinterface
`default_nettype wire

[src/fcq_out_if.sv]
`default_nettype none
interface fcq_out_if;
    logic             valid;
    logic             ready;
    fcq_pkg::filt_t   filtered;

    modport source (output valid, output filtered, input ready);
    modport sink (input valid, input filtered, output ready);
endinterface
`default_nettype wire

[src/fcq_ram.sv]
`default_nettype none
module fcq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[src/fcq_mac.sv]
`default_nettype none
module fcq_mac (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fcq_pkg::mac_ctrl_t  ctrl,
    input  wire fcq_pkg::coef_t      coef,
    input  wire fcq_pkg::sample_t    sample,
    output fcq_pkg::filt_t           acc
);

    logic signed [fcq_pkg::PROD_W-1:0] prod_reg;
    logic signed [fcq_pkg::PROD_W-1:0] prod_next;
    logic                              prod_valid_reg;
    fcq_pkg::filt_t                    acc_reg;
    fcq_pkg::filt_t                    acc_next;
    fcq_pkg::filt_t                    prod_shifted;

    assign prod_next = coef * sample;

    // arithmetic shift by 15, sign-extended to the accumulator width
    assign prod_shifted = fcq_pkg::filt_t'(prod_reg >>> fcq_pkg::Q15_SHIFT);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + prod_shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctrl.data_valid;
            acc_reg        <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

[src/fcq_seq.sv]
`default_nettype none
module fcq_seq #(
    parameter int TAPS = 64,
    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    fcq_in_if.sink                  items,
    fcq_out_if.source               results,
    output logic                    hist_wr_en,
    output logic [AW-1:0]           hist_wr_addr,
    output fcq_pkg::sample_t        hist_wr_data,
    output logic [AW-1:0]           hist_rd_addr,
    output logic                    coef_wr_en,
    output logic [AW-1:0]           coef_wr_addr,
    output fcq_pkg::coef_t          coef_wr_data,
    output logic [AW-1:0]           coef_rd_addr,
    output fcq_pkg::mac_ctrl_t      mac_ctrl,
    input  wire fcq_pkg::filt_t     acc
);

    localparam logic [AW-1:0] LAST_POS = AW'(TAPS - 1);

    fcq_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             issue_reg, issue_next;
    fcq_pkg::sample_t lat_sample_reg;
    logic             lat_filter_reg;
    logic             out_valid_reg, out_valid_next;
    fcq_pkg::filt_t   out_filtered_reg;

    logic             accept;
    logic             cnt_last;
    logic             tap_ok;
    logic [31:0]      tap_wide;
    logic             out_load;
    logic [AW-1:0]    cnt_inc;
    logic [AW-1:0]    pos_dec;
    logic [AW-1:0]    idx_inc;

    assign accept   = (state_reg == fcq_pkg::ST_IDLE) && items.valid;
    assign cnt_last = (cnt_reg == LAST_POS);
    assign cnt_inc  = cnt_last ? '0 : cnt_reg + 1'b1;
    assign pos_dec  = (pos_reg == '0) ? LAST_POS : pos_reg - 1'b1;
    assign idx_inc  = (idx_reg == LAST_POS) ? '0 : idx_reg + 1'b1;
    assign tap_wide = 32'(items.tap_index);
    assign tap_ok   = (tap_wide < 32'(TAPS));
    assign out_load = (state_reg == fcq_pkg::ST_DONE) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fcq_pkg::ST_INIT:
            begin
                if (cnt_last)
                begin
                    state_next = fcq_pkg::ST_IDLE;
                end
            end
            fcq_pkg::ST_IDLE:
            begin
                if (items.valid)
                begin
                    unique case (items.action)
                        fcq_pkg::ACT_FILTER: state_next = fcq_pkg::ST_WRITE;
                        fcq_pkg::ACT_CLEAR:  state_next = fcq_pkg::ST_CLEAR;
                        default:             state_next = fcq_pkg::ST_DONE;
                    endcase
                end
            end
            fcq_pkg::ST_WRITE:  state_next = fcq_pkg::ST_RUN;
            fcq_pkg::ST_RUN:
            begin
                if (cnt_last)
                begin
                    state_next = fcq_pkg::ST_DRAIN1;
                end
            end
            fcq_pkg::ST_DRAIN1: state_next = fcq_pkg::ST_DRAIN2;
            fcq_pkg::ST_DRAIN2: state_next = fcq_pkg::ST_DONE;
            fcq_pkg::ST_CLEAR:
            begin
                if (cnt_last)
                begin
                    state_next = fcq_pkg::ST_DONE;
                end
            end
            fcq_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = fcq_pkg::ST_IDLE;
                end
            end
            default:            state_next = fcq_pkg::ST_INIT;
        endcase
    end

    always_comb
    begin
        items.ready         = 1'b0;
        hist_wr_en          = 1'b0;
        hist_wr_addr        = pos_reg;
        hist_wr_data        = lat_sample_reg;
        hist_rd_addr        = idx_reg;
        coef_wr_en          = 1'b0;
        coef_wr_addr        = tap_wide[AW-1:0];
        coef_wr_data        = items.coefficient;
        coef_rd_addr        = cnt_reg;
        mac_ctrl.clear      = 1'b0;
        mac_ctrl.data_valid = issue_reg;
        cnt_next            = cnt_reg;
        pos_next            = pos_reg;
        idx_next            = idx_reg;
        issue_next          = 1'b0;
        unique case (state_reg)
            fcq_pkg::ST_INIT:
            begin
                // zero both memories after reset
                hist_wr_en   = 1'b1;
                hist_wr_addr = cnt_reg;
                hist_wr_data = '0;
                coef_wr_en   = 1'b1;
                coef_wr_addr = cnt_reg;
                coef_wr_data = '0;
                cnt_next     = cnt_inc;
            end
            fcq_pkg::ST_IDLE:
            begin
                items.ready = 1'b1;
                if (accept)
                begin
                    cnt_next = '0;
                    if (items.action == fcq_pkg::ACT_FILTER)
                    begin
                        pos_next = pos_dec;
                    end
                    // out-of-range tap writes are dropped
                    coef_wr_en = (items.action == fcq_pkg::ACT_COEF) && tap_ok;
                end
            end
            fcq_pkg::ST_WRITE:
            begin
                hist_wr_en     = 1'b1;
                idx_next       = pos_reg;
                cnt_next       = '0;
                mac_ctrl.clear = 1'b1;
            end
            fcq_pkg::ST_RUN:
            begin
                issue_next = 1'b1;
                idx_next   = idx_inc;
                cnt_next   = cnt_inc;
            end
            fcq_pkg::ST_CLEAR:
            begin
                hist_wr_en   = 1'b1;
                hist_wr_addr = cnt_reg;
                hist_wr_data = '0;
                cnt_next     = cnt_inc;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcq_pkg::ST_INIT;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            issue_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            issue_reg     <= issue_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lat_sample_reg <= items.sample;
            lat_filter_reg <= (items.action == fcq_pkg::ACT_FILTER);
        end
        if (out_load)
        begin
            out_filtered_reg <= lat_filter_reg ? acc : '0;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.filtered = out_filtered_reg;

endmodule
`default_nettype wire

[src/fir_filter_circular_q15.sv]
// channel   dir   fields                                      request accepted when
// items     in    action, sample, tap_index, coefficient     valid && ready
// results   out   filtered                                    valid && ready
//
// a filter request does one history write, then one shared multiply-accumulate stepping
// through a tap per cycle (read, product, accumulate), fed by the history and coefficient
// memories.
// a coefficient write is made as the request is accepted; a history clear sweeps one entry a cycle.
// after reset both memories are zeroed, entry by entry, before the first request is taken.
// a finished result waits in the output register; the next request is taken meanwhile.
`default_nettype none
module fir_filter_circular_q15 #(
    parameter int TAPS = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fcq_in_if.sink      items,
    fcq_out_if.source   results
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;

    logic                hist_wr_en;
    logic [AW-1:0]       hist_wr_addr;
    fcq_pkg::sample_t    hist_wr_data;
    logic [AW-1:0]       hist_rd_addr;
    fcq_pkg::sample_t    hist_rd_data;
    logic                coef_wr_en;
    logic [AW-1:0]       coef_wr_addr;
    fcq_pkg::coef_t      coef_wr_data;
    logic [AW-1:0]       coef_rd_addr;
    fcq_pkg::coef_t      coef_rd_data;
    fcq_pkg::mac_ctrl_t  mac_ctrl;
    fcq_pkg::filt_t      acc;

    fcq_ram #(
        .WIDTH (fcq_pkg::SAMPLE_W),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (hist_wr_en),
        .wr_addr (hist_wr_addr),
        .wr_data (hist_wr_data),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd_data)
    );

    fcq_ram #(
        .WIDTH (fcq_pkg::COEF_W),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_wr_en),
        .wr_addr (coef_wr_addr),
        .wr_data (coef_wr_data),
        .rd_addr (coef_rd_addr),
        .rd_data (coef_rd_data)
    );

    fcq_seq #(
        .TAPS (TAPS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .items        (items),
        .results      (results),
        .hist_wr_en   (hist_wr_en),
        .hist_wr_addr (hist_wr_addr),
        .hist_wr_data (hist_wr_data),
        .hist_rd_addr (hist_rd_addr),
        .coef_wr_en   (coef_wr_en),
        .coef_wr_addr (coef_wr_addr),
        .coef_wr_data (coef_wr_data),
        .coef_rd_addr (coef_rd_addr),
        .mac_ctrl     (mac_ctrl),
        .acc          (acc)
    );

    fcq_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .coef   (coef_rd_data),
        .sample (hist_rd_data),
        .acc    (acc)
    );

endmodule
`default_nettype wire
